// ===== rtl/crrt_pkg.sv =====
// Shared types and constants for the character range reject and translate block.
// No dependencies; used by crrt_front, crrt_back and the top level.
package crrt_pkg;

  localparam int CODE_W      = 21;
  localparam int IN_TDATA_W  = 112;  // 5 x 21 bits, padded to whole bytes
  localparam int OUT_TDATA_W = 24;   // 21 bits, padded to whole bytes
  localparam int OUT_TUSER_W = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_PAIR  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Classified item type, decoded once in the front end.
  typedef struct packed {
    logic is_char;
    logic is_range;
    logic is_pair;
    logic is_clear;
  } ctrl_t;

  typedef struct packed {
    ctrl_t             ctrl;
    logic [CODE_W-1:0] code_point;
    logic              end_of_string;
    logic [CODE_W-1:0] range_start;
    logic [CODE_W-1:0] range_end;
    logic [CODE_W-1:0] match_code;
    logic [CODE_W-1:0] substitute_code;
  } item_t;

endpackage

// ===== rtl/char_range_reject_and_translate.sv =====
// Top level of the character range reject and translate block.
// Depends on crrt_pkg, crrt_front and crrt_back.
//
//  Channel | Ports          | tdata (low bit up)                    | tuser / tlast
//  --------+----------------+---------------------------------------+------------------------
//  input   | in_t*          | code_point, range_start, range_end,   | kind / end_of_string
//          |                | match_code, substitute_code, pad      |
//  result  | out_t*         | out_code, pad                         | rejected, table_overflow
//          |                |                                       | / last_of_string
//
// One item per cycle sustained while the result side is not stalled: a transfer
// enters the 4-entry queue, the back end retires one item per cycle with all range
// and pair comparators in parallel. With an empty queue, result valid rises after
// the queue write and then the result register; the result then waits on out_tready.
// Load and clear items produce no result and never wait on out_tready.
// rst_n is synchronous, active low; tables come up empty (counts zero).
// A stalled result holds its register while the queue keeps taking transfers until full.
module char_range_reject_and_translate #(
  parameter int RANGE_ENTRIES = 16,
  parameter int PAIR_ENTRIES  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [20:0] code_point, [41:21] range_start, [62:42] range_end,
  // [83:63] match_code, [104:84] substitute_code, [111:105] zero
  input  logic [crrt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] kind
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [20:0] out_code, [23:21] zero
  output logic [crrt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] rejected, [1] table_overflow
  output logic [crrt_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast
);

  logic            q_valid;
  logic            q_pop;
  crrt_pkg::item_t q_item;

  // Accept, classify, queue.
  crrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Table update, lookup, result register.
  crrt_back #(
    .RANGE_ENTRIES (RANGE_ENTRIES),
    .PAIR_ENTRIES  (PAIR_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/crrt_front.sv =====
// Front end: accepts input transfers, classifies the item kind, queues items.
// Depends on crrt_pkg.
module crrt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crrt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tlast,
  output logic                                q_valid,
  output crrt_pkg::item_t                     q_item,
  input  logic                                q_pop
);

  crrt_pkg::item_t                  fifo_r [crrt_pkg::FIFO_DEPTH];
  logic [crrt_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [crrt_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [crrt_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;
  crrt_pkg::item_t                  in_item;
  crrt_pkg::ctrl_t                  ctrl;
  logic                             push;
  logic                             pop;

  always_comb begin
    ctrl = '0;
    case (crrt_pkg::kind_t'(in_tuser))
      crrt_pkg::KIND_CHAR:  ctrl.is_char  = 1'b1;
      crrt_pkg::KIND_RANGE: ctrl.is_range = 1'b1;
      crrt_pkg::KIND_PAIR:  ctrl.is_pair  = 1'b1;
      crrt_pkg::KIND_CLEAR: ctrl.is_clear = 1'b1;
      default:              ctrl = '0;
    endcase
  end

  always_comb begin
    in_item.ctrl            = ctrl;
    in_item.code_point      = in_tdata[20:0];
    in_item.end_of_string   = in_tlast;
    in_item.range_start     = in_tdata[41:21];
    in_item.range_end       = in_tdata[62:42];
    in_item.match_code      = in_tdata[83:63];
    in_item.substitute_code = in_tdata[104:84];
  end

  assign in_tready = (cnt_r != crrt_pkg::FIFO_CW'(crrt_pkg::FIFO_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/crrt_back.sv =====
// Back end: range and pair tables, parallel lookup, sticky flags, result register.
// Depends on crrt_pkg.
module crrt_back #(
  parameter int RANGE_ENTRIES = 16,
  parameter int PAIR_ENTRIES  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  crrt_pkg::item_t                     q_item,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [crrt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [crrt_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);

  localparam int RCW = $clog2(RANGE_ENTRIES + 1);
  localparam int PCW = $clog2(PAIR_ENTRIES + 1);

  logic [crrt_pkg::CODE_W-1:0] rlo_r [RANGE_ENTRIES];
  logic [crrt_pkg::CODE_W-1:0] rhi_r [RANGE_ENTRIES];
  logic [crrt_pkg::CODE_W-1:0] mt_r  [PAIR_ENTRIES];
  logic [crrt_pkg::CODE_W-1:0] st_r  [PAIR_ENTRIES];
  logic [RCW-1:0]              range_cnt_r;
  logic [PCW-1:0]              pair_cnt_r;
  logic                        reject_r;
  logic                        overflow_r;
  logic                        out_valid_r;
  logic [crrt_pkg::CODE_W-1:0] out_code_r;
  logic                        out_rej_r;
  logic                        out_last_r;
  logic                        out_ovf_r;

  logic                        out_free;
  logic                        blocked;
  logic                        sub_hit;
  logic [crrt_pkg::CODE_W-1:0] sub_code;
  logic                        rej_now;
  logic [crrt_pkg::CODE_W-1:0] code_now;
  logic                        range_room;
  logic                        pair_room;
  logic                        do_char;
  logic                        do_range;
  logic                        do_pair;
  logic                        do_clear;

  assign out_free = !out_valid_r || out_tready;
  // Loads and clears never wait on the result side.
  assign q_pop    = q_valid && (!q_item.ctrl.is_char || out_free);
  assign do_char  = q_pop && q_item.ctrl.is_char;
  assign do_range = q_pop && q_item.ctrl.is_range;
  assign do_pair  = q_pop && q_item.ctrl.is_pair;
  assign do_clear = q_pop && q_item.ctrl.is_clear;

  assign range_room = (range_cnt_r < RCW'(RANGE_ENTRIES));
  assign pair_room  = (pair_cnt_r < PCW'(PAIR_ENTRIES));

  // Parallel range compare over filled entries.
  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < RANGE_ENTRIES; i++) begin
      if ((RCW'(i) < range_cnt_r) && (q_item.code_point >= rlo_r[i]) &&
          (q_item.code_point <= rhi_r[i])) begin
        blocked = 1'b1;
      end
    end
  end

  // Pair match, lowest filled index wins.
  always_comb begin
    sub_hit  = 1'b0;
    sub_code = q_item.code_point;
    for (int i = PAIR_ENTRIES - 1; i >= 0; i--) begin
      if ((PCW'(i) < pair_cnt_r) && (q_item.code_point == mt_r[i])) begin
        sub_hit  = 1'b1;
        sub_code = st_r[i];
      end
    end
  end

  assign rej_now  = reject_r || blocked;
  assign code_now = rej_now ? '0 : (sub_hit ? sub_code : q_item.code_point);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_cnt_r <= '0;
      pair_cnt_r  <= '0;
      reject_r    <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= do_char;
      end
      if (do_char) begin
        reject_r <= rej_now && !q_item.end_of_string;
      end
      if (do_range) begin
        if (range_room) begin
          range_cnt_r <= range_cnt_r + 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if (do_pair) begin
        if (pair_room) begin
          pair_cnt_r <= pair_cnt_r + 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if (do_clear) begin
        range_cnt_r <= '0;
        pair_cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RANGE_ENTRIES; i++) begin
      if (do_range && (range_cnt_r == RCW'(i))) begin
        rlo_r[i] <= q_item.range_start;
        rhi_r[i] <= q_item.range_end;
      end
    end
    for (int i = 0; i < PAIR_ENTRIES; i++) begin
      if (do_pair && (pair_cnt_r == PCW'(i))) begin
        mt_r[i] <= q_item.match_code;
        st_r[i] <= q_item.substitute_code;
      end
    end
    if (do_char) begin
      out_code_r <= code_now;
      out_rej_r  <= rej_now;
      out_last_r <= q_item.end_of_string;
      out_ovf_r  <= overflow_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(crrt_pkg::OUT_TDATA_W - crrt_pkg::CODE_W){1'b0}}, out_code_r};
  assign out_tuser  = {out_ovf_r, out_rej_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== verif/char_range_reject_and_translate_test.sv =====
// Self-checking testbench for char_range_reject_and_translate: directed and random
// strings, table loads and clears, checked against a scoreboard with its own predictor.
// Depends on crrt_pkg and the char_range_reject_and_translate RTL.

// One result transfer as seen on the out_* channel.
typedef struct packed {
  logic [20:0] code;
  logic        rejected;
  logic        last;
  logic        overflow;
} char_result_t;

// Tracks the block's tables and sticky flags and queues the result each
// accepted character should produce.
class crrt_scoreboard #(int RANGES = 16, int PAIRS = 16);
  logic [20:0]  range_lo[RANGES];
  logic [20:0]  range_hi[RANGES];
  logic [20:0]  match_codes[PAIRS];
  logic [20:0]  subst_codes[PAIRS];
  int unsigned  range_cnt = 0;
  int unsigned  pair_cnt = 0;
  bit           string_rejected = 0;
  bit           overflowed = 0;
  char_result_t pending_q[$];
  int unsigned  mismatches = 0;

  function void note_transfer(crrt_pkg::kind_t kind, logic [20:0] cp, logic eos,
                              logic [20:0] lo, logic [20:0] hi,
                              logic [20:0] mc, logic [20:0] sc);
    char_result_t res;
    logic [20:0]  code;
    case (kind)
      crrt_pkg::KIND_RANGE: begin
        if (range_cnt < RANGES) begin
          range_lo[range_cnt] = lo;
          range_hi[range_cnt] = hi;
          range_cnt++;
        end else begin
          overflowed = 1;
        end
      end
      crrt_pkg::KIND_PAIR: begin
        if (pair_cnt < PAIRS) begin
          match_codes[pair_cnt] = mc;
          subst_codes[pair_cnt] = sc;
          pair_cnt++;
        end else begin
          overflowed = 1;
        end
      end
      crrt_pkg::KIND_CLEAR: begin
        // sticky flags survive a clear
        range_cnt = 0;
        pair_cnt = 0;
      end
      default: begin
        if (!string_rejected) begin
          for (int i = 0; i < int'(range_cnt); i++) begin
            if (cp >= range_lo[i] && cp <= range_hi[i]) string_rejected = 1;
          end
        end
        code = cp;
        if (string_rejected) begin
          code = '0;
        end else begin
          // walk backwards so the earliest matching pair wins
          for (int i = int'(pair_cnt) - 1; i >= 0; i--) begin
            if (cp == match_codes[i]) code = subst_codes[i];
          end
        end
        res.code = code;
        res.rejected = string_rejected;
        res.last = eos;
        res.overflow = overflowed;
        pending_q.push_back(res);
        if (eos) string_rejected = 0;
      end
    endcase
  endfunction

  function void check_transfer(char_result_t got);
    char_result_t want;
    bit bad;
    bad = 0;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got code=%h rej=%b last=%b ovf=%b",
               $time, got.code, got.rejected, got.last, got.overflow);
      mismatches++;
      return;
    end
    want = pending_q.pop_front();
    if (got.code !== want.code) begin
      $display("%0t: out_code expected %h got %h", $time, want.code, got.code);
      bad = 1;
    end
    if (got.rejected !== want.rejected) begin
      $display("%0t: rejected expected %b got %b", $time, want.rejected, got.rejected);
      bad = 1;
    end
    if (got.last !== want.last) begin
      $display("%0t: last_of_string expected %b got %b", $time, want.last, got.last);
      bad = 1;
    end
    if (got.overflow !== want.overflow) begin
      $display("%0t: table_overflow expected %b got %b", $time, want.overflow, got.overflow);
      bad = 1;
    end
    if (bad) mismatches++;
  endfunction

  function int unsigned outstanding();
    return pending_q.size();
  endfunction
endclass

module char_range_reject_and_translate_test;
  import crrt_pkg::*;

  localparam int RANGE_ENTRIES   = 16;
  localparam int PAIR_ENTRIES    = 16;
  // random part; the directed pass and the overfill add about 55 more
  localparam int RANDOM_ITEMS    = 345;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOT_DEPTH       = 24;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned tx_gap_pct = 18;
  int unsigned rx_stall_pct = 74;
  int unsigned items_sent = 0;

  // recently loaded codes; characters are often drawn near them so that
  // ranges and pairs actually get hit
  logic [20:0] hot_q[$];

  crrt_scoreboard #(RANGE_ENTRIES, PAIR_ENTRIES) sb = new;

  char_range_reject_and_translate #(
    .RANGE_ENTRIES(RANGE_ENTRIES),
    .PAIR_ENTRIES (PAIR_ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [20:0] rnd21();
    return 21'($urandom);
  endfunction

  function automatic void remember(logic [20:0] code);
    hot_q.push_back(code);
    if (hot_q.size() > HOT_DEPTH) void'(hot_q.pop_front());
  endfunction

  // Code point for a character or a load: near a loaded code, an extreme,
  // plain ASCII, or anything in 21 bits.
  function automatic logic [20:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35 && hot_q.size() != 0)
      return hot_q[$urandom_range(hot_q.size() - 1)] + 21'($urandom_range(2)) - 21'd1;
    if (r < 45) begin
      case ($urandom_range(3))
        0: return 21'h000000;
        1: return 21'h10FFFF;
        2: return 21'h110000;
        default: return 21'h1FFFFF;
      endcase
    end
    if (r < 70) return 21'($urandom_range(8'h7F));
    return rnd21();
  endfunction

  // One input transfer. A random gap (valid low) may come first; valid
  // stays high between back-to-back transfers.
  task automatic push_item(kind_t kind, logic [20:0] cp, logic eos, logic [20:0] lo,
                           logic [20:0] hi, logic [20:0] mc, logic [20:0] sc);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 5 * CODE_W){1'b0}}, sc, mc, hi, lo, cp};
    in_tuser  <= kind;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(kind, cp, eos, lo, hi, mc, sc);
    items_sent++;
  endtask

  // Unused fields carry random junk so the block must ignore them.
  task automatic send_char(logic [20:0] cp, logic eos);
    push_item(KIND_CHAR, cp, eos, rnd21(), rnd21(), rnd21(), rnd21());
  endtask

  task automatic send_range(logic [20:0] lo, logic [20:0] hi);
    remember(lo);
    remember(hi);
    push_item(KIND_RANGE, rnd21(), 1'($urandom), lo, hi, rnd21(), rnd21());
  endtask

  task automatic send_pair(logic [20:0] mc, logic [20:0] sc);
    remember(mc);
    push_item(KIND_PAIR, rnd21(), 1'($urandom), rnd21(), rnd21(), mc, sc);
  endtask

  task automatic send_clear();
    push_item(KIND_CLEAR, rnd21(), 1'($urandom), rnd21(), rnd21(), rnd21(), rnd21());
  endtask

  // Mostly narrow ranges so strings are not rejected wholesale; some wide,
  // some empty (start above end).
  task automatic send_random_range();
    logic [20:0] lo;
    logic [20:0] hi;
    int unsigned r;
    lo = pick_code();
    r = $urandom_range(99);
    if (r < 10) begin
      hi = lo;
      lo = lo + 21'($urandom_range(64, 1));
    end else if (r < 20) begin
      hi = lo + 21'($urandom_range(4095));
    end else begin
      hi = lo + 21'($urandom_range(8));
    end
    send_range(lo, hi);
  endtask

  task automatic send_random_pair();
    send_pair(pick_code(), ($urandom_range(1) != 0) ? pick_code() : rnd21());
  endtask

  task automatic load_burst(int unsigned n_ranges, int unsigned n_pairs);
    repeat (n_ranges) send_random_range();
    repeat (n_pairs) send_random_pair();
  endtask

  // A load or clear dropped into the middle of a string.
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_random_range();
      1: send_random_pair();
      default: send_clear();
    endcase
  endtask

  task automatic send_string();
    int unsigned len;
    len = $urandom_range(8, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_noise();
      send_char(pick_code(), i == len - 1);
    end
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned start;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_clear();
        load_burst($urandom_range(6), $urandom_range(6));
      end else if (r < 25) begin
        load_burst($urandom_range(5), $urandom_range(5));
      end else begin
        send_string();
      end
    end
  endtask

  // Hold the input channel quiet until every queued result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Directed pass: empty tables, field extremes, an empty range, duplicate
  // match codes, a rejected string with trailing characters, a clear in the
  // middle of a rejected string.
  task automatic run_directed();
    send_char(21'h000000, 1'b0);
    send_char(21'h1FFFFF, 1'b1);      // above the Unicode limit, plain 21-bit value
    send_range(21'h000000, 21'h000000);
    send_range(21'h1FFFF0, 21'h1FFFFF);
    send_range(21'h000200, 21'h000100); // empty: start above end
    send_range(21'h000041, 21'h00005A);
    send_pair(21'h000061, 21'h00007A);
    send_pair(21'h000061, 21'h000030); // shadowed by the earlier pair
    send_pair(21'h10FFFF, 21'h1FFFFF);
    send_char(21'h000061, 1'b0);
    send_char(21'h10FFFF, 1'b0);
    send_char(21'h000150, 1'b0);      // inside the empty range, still passes
    send_char(21'h000041, 1'b0);      // blocked: string rejected from here
    send_char(21'h000061, 1'b0);
    send_char(21'h000062, 1'b1);
    send_char(21'h000062, 1'b1);      // fresh string passes again
    send_char(21'h000000, 1'b1);
    send_char(21'h1FFFFF, 1'b0);
    send_clear();                     // reject mark must survive the clear
    send_char(21'h00005A, 1'b1);
    send_char(21'h000061, 1'b1);
  endtask

  // Receiver: check on each output transfer, then pick the next ready.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_transfer({out_tdata[CODE_W-1:0], out_tuser[0], out_tlast, out_tuser[1]});
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: the run is hung if neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_CHAR;
    in_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles a little, receiver a lot
    tx_gap_pct = 18;
    rx_stall_pct = 74;
    run_directed();
    drain();
    // overfill both tables once so the overflow flag gets exercised
    load_burst(RANGE_ENTRIES + 1, PAIR_ENTRIES + 1);
    run_random(RANDOM_ITEMS / 3);
    drain();

    // phase 2: roles swapped
    tx_gap_pct = 74;
    rx_stall_pct = 18;
    run_random(RANDOM_ITEMS / 3);
    drain();

    // phase 3: full throughput both sides
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    run_random(RANDOM_ITEMS / 3);
    drain();

    // keep the clock running so a stray late result would still be caught
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
